// ===== design/free_space_candidate_bucket_core_macros.svh =====
// Assertion macros for the checker file of the candidate bucket core.
// Each macro expects clk and arst_n to exist in the scope that uses it.
`ifndef FREE_SPACE_CANDIDATE_BUCKET_CORE_MACROS_SVH
`define FREE_SPACE_CANDIDATE_BUCKET_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FSCB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FSCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fscb_pkg.sv =====
// Shared constants, codes and word types of the candidate bucket core.
// No dependencies; fscb_seq, fscb_out_buf, the top level and the checker import it.
package fscb_pkg;

	localparam int CAPACITY    = 16;
	localparam int LEVEL_COUNT = 8;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int SEQ_W   = 32;
	localparam int PAGE_W  = 32;
	localparam int LEVEL_W = 4;
	localparam int FAIL_W  = 8;
	localparam int HELD_W  = 5;

	localparam logic [FAIL_W-1:0] FAIL_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_UPSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_BAD_LEVEL = 1'b1
	} status_t;

	// One table entry as stored in the memory
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [PAGE_W-1:0]  page;
		logic [LEVEL_W-1:0] level;
		logic [FAIL_W-1:0]  fails;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		op_t                op;
		logic [SEQ_W-1:0]   seq;
		logic [PAGE_W-1:0]  page;
		logic [LEVEL_W-1:0] level;
	} request_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [SEQ_W-1:0]   seq;
		logic [PAGE_W-1:0]  page;
		logic [LEVEL_W-1:0] level;
		logic [HELD_W-1:0]  held;
		logic               last;
	} result_t;

endpackage

// ===== design/fscb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fscb_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write the addressed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read word; hold it while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/fscb_seq.sv =====
// Operation sequencer of the candidate bucket core: slot scans over the entry
// memory, valid bits, occupancy and rotating start. Uses fscb_pkg, fscb_ram.
module fscb_seq
	import fscb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  request_t req,
	output logic     res_valid,
	input  logic     res_ready,
	output result_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPS_WR,
		ST_RESP,
		ST_DUMP_RD,
		ST_DUMP_EMIT
	} state_t;

	state_t               state_q;
	logic [CAPACITY-1:0]  valid_q;
	logic [CNT_W-1:0]     occ_q;
	logic [IDX_W-1:0]     rc_q;
	logic [IDX_W-1:0]     addr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 vld_s1;
	result_t              res_q;

	op_t                  op_q;
	logic [SEQ_W-1:0]     seq_q;
	logic [PAGE_W-1:0]    page_q;
	logic [LEVEL_W-1:0]   lvl_q;
	logic [IDX_W-1:0]     addr_s1;
	logic                 last_s1;
	logic                 empty_found_q;
	logic [IDX_W-1:0]     empty_pos_q;
	logic                 have_best_q;
	logic [FAIL_W-1:0]    best_fail_q;
	logic [IDX_W-1:0]     best_pos_q;
	logic [IDX_W-1:0]     pos_q;

	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	entry_t               wr_data;
	entry_t               rdata;

	logic                 accept;
	logic                 lvl_ok;
	logic                 issue;
	logic                 slot_valid_s1;
	logic                 hit_s1;
	logic                 scan_done;
	logic                 ef_n;
	logic [IDX_W-1:0]     ep_n;
	logic                 hb_n;
	logic [FAIL_W-1:0]    bf_n;
	logic [IDX_W-1:0]     bp_n;
	logic [IDX_W-1:0]     addr_wrap;
	logic [IDX_W-1:0]     rc_next;
	logic [CAPACITY-1:0]  above_mask;
	logic                 dump_last;
	result_t              dump_res;

	fscb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign lvl_ok    = ({1'b0, req.level} < (LEVEL_W + 1)'(LEVEL_COUNT));

	// Scan addressing: wrap the slot pointer and the rotating start
	assign addr_wrap = (addr_q == IDX_W'(CAPACITY - 1)) ? '0 : addr_q + IDX_W'(1);
	assign rc_next   = (rc_q == IDX_W'(CAPACITY - 1)) ? '0 : rc_q + IDX_W'(1);
	assign issue     = (state_q == ST_SCAN) && (cnt_q != CNT_W'(CAPACITY));

	// Slot arriving from memory
	assign slot_valid_s1 = valid_q[addr_s1];
	assign hit_s1        = vld_s1 && (op_q == OP_FIND) && slot_valid_s1 &&
	                       (lvl_q <= rdata.level);
	assign scan_done     = vld_s1 && (hit_s1 || last_s1);

	// Track first empty slot and highest failure count for upsert
	always_comb begin
		ef_n = empty_found_q;
		ep_n = empty_pos_q;
		hb_n = have_best_q;
		bf_n = best_fail_q;
		bp_n = best_pos_q;
		if (vld_s1 && (op_q == OP_UPSERT)) begin
			if (!slot_valid_s1) begin
				if (!empty_found_q) begin
					ef_n = 1'b1;
					ep_n = addr_s1;
				end
			end else if (!have_best_q || (rdata.fails > best_fail_q)) begin
				hb_n = 1'b1;
				bf_n = rdata.fails;
				bp_n = addr_s1;
			end
		end
	end

	// Dump: does any valid slot follow the current one
	always_comb begin
		for (int j = 0; j < CAPACITY; j++) begin
			above_mask[j] = (j > int'(addr_q));
		end
	end
	assign dump_last = ~|(valid_q & above_mask);

	always_comb begin
		dump_res        = '0;
		dump_res.status = STATUS_OK;
		dump_res.found  = 1'b1;
		dump_res.seq    = rdata.seq;
		dump_res.page   = rdata.page;
		dump_res.level  = rdata.level;
		dump_res.held   = HELD_W'(occ_q);
		dump_res.last   = dump_last;
	end

	// Memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q;
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = rdata;
		if (issue) begin
			rd_en = 1'b1;
		end
		if (state_q == ST_DUMP_RD && valid_q[addr_q]) begin
			rd_en = 1'b1;
		end
		// Raise the failure count of a passed-over valid slot
		if (vld_s1 && (op_q == OP_FIND) && slot_valid_s1 && !hit_s1 &&
		    (rdata.fails != FAIL_MAX)) begin
			wr_en         = 1'b1;
			wr_data.fails = rdata.fails + FAIL_W'(1);
		end
		if (state_q == ST_UPS_WR) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = '{seq: seq_q, page: page_q, level: lvl_q, fails: '0};
		end
	end

	assign res_valid = (state_q == ST_RESP) || (state_q == ST_DUMP_EMIT);
	assign res       = (state_q == ST_DUMP_EMIT) ? dump_res : res_q;

	// State, table control and the single-result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			occ_q   <= '0;
			rc_q    <= '0;
			addr_q  <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			res_q   <= '0;
		end else begin
			vld_s1 <= issue && !scan_done;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q        <= '0;
						res_q.status <= STATUS_OK;
						res_q.held   <= HELD_W'(occ_q);
						res_q.last   <= 1'b1;
						unique case (req.op)
							OP_UPSERT, OP_FIND: begin
								if (!lvl_ok) begin
									res_q.status <= STATUS_BAD_LEVEL;
									state_q      <= ST_RESP;
								end else begin
									addr_q  <= (req.op == OP_FIND) ? rc_q : '0;
									cnt_q   <= '0;
									state_q <= ST_SCAN;
									if (req.op == OP_FIND) begin
										rc_q <= rc_next;
									end
								end
							end
							OP_CLEAR: begin
								valid_q    <= '0;
								occ_q      <= '0;
								res_q.held <= '0;
								state_q    <= ST_RESP;
							end
							OP_DUMP: begin
								addr_q  <= '0;
								state_q <= (occ_q == '0) ? ST_RESP : ST_DUMP_RD;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= addr_wrap;
						cnt_q  <= cnt_q + CNT_W'(1);
					end
					if (scan_done) begin
						if (op_q == OP_FIND) begin
							res_q.found <= hit_s1;
							res_q.seq   <= hit_s1 ? rdata.seq : '0;
							res_q.page  <= hit_s1 ? rdata.page : '0;
							res_q.level <= hit_s1 ? rdata.level : '0;
							state_q     <= ST_RESP;
						end else begin
							state_q <= ST_UPS_WR;
						end
					end
				end
				ST_UPS_WR: begin
					valid_q[pos_q] <= 1'b1;
					if (!valid_q[pos_q]) begin
						occ_q      <= occ_q + CNT_W'(1);
						res_q.held <= HELD_W'(occ_q + CNT_W'(1));
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP_RD: begin
					if (valid_q[addr_q]) begin
						state_q <= ST_DUMP_EMIT;
					end else begin
						addr_q <= addr_wrap;
					end
				end
				ST_DUMP_EMIT: begin
					if (res_ready) begin
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							addr_q  <= addr_wrap;
							state_q <= ST_DUMP_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields and scan bookkeeping
	always_ff @(posedge clk) begin
		addr_s1       <= addr_q;
		last_s1       <= (cnt_q == CNT_W'(CAPACITY - 1));
		empty_found_q <= ef_n;
		empty_pos_q   <= ep_n;
		have_best_q   <= hb_n;
		best_fail_q   <= bf_n;
		best_pos_q    <= bp_n;
		if (scan_done) begin
			pos_q <= ef_n ? ep_n : bp_n;
		end
		if (accept) begin
			op_q          <= req.op;
			seq_q         <= req.seq;
			page_q        <= req.page;
			lvl_q         <= req.level;
			empty_found_q <= 1'b0;
			have_best_q   <= 1'b0;
		end
	end

endmodule

// ===== design/fscb_out_buf.sv =====
// Output register of the candidate bucket core: holds one result word
// so the sequencer can go on while it waits. Uses fscb_pkg.
module fscb_out_buf
	import fscb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = data_q;

	// Load on push, drop on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_res;
		end
	end

endmodule

// ===== design/free_space_candidate_bucket_core.sv =====
// Channel  Dir  Handshake          tuser (low bit up)    tdata (low bit up)
// s_       in   s_tvalid/s_tready  operation             seq_in, page_in, level_in
// m_       out  m_tvalid/m_tready  status, found         seq_out, page_out, level_out,
//                                                        entries_held; m_tlast = last
//
// One request at a time. Upsert reads all CAPACITY slots, one per cycle, then writes.
// Find scans from a rotating start and stops at the first hit, else visits every slot.
// Clear, bad-level and empty dump return a single result. Dump returns one result per
// valid entry, in slot order, skipping empty slots. Reset empties the table at once.
// A stalled m_ side holds the sequencer once the output register is full. Top level of
// the core; uses fscb_pkg, fscb_seq, fscb_out_buf.
module free_space_candidate_bucket_core
	import fscb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // operation
	input  logic [71:0] s_tdata,  // seq_in, page_in, level_in, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,  // status, found
	output logic [79:0] m_tdata,  // seq_out, page_out, level_out, entries_held, zero pad
	output logic        m_tlast
);

	request_t req;
	logic     res_valid;
	logic     res_ready;
	result_t  res;
	result_t  out_res;

	// Unpack the request word
	assign req.op    = op_t'(s_tuser);
	assign req.seq   = s_tdata[31:0];
	assign req.page  = s_tdata[63:32];
	assign req.level = s_tdata[67:64];

	fscb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	fscb_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	// Pack the result word
	assign m_tuser = {out_res.found, out_res.status};
	assign m_tdata = {7'b0, out_res.held, out_res.level, out_res.page, out_res.seq};
	assign m_tlast = out_res.last;

endmodule

// ===== design/fscb_checker.sv =====
// Port-level checks of the candidate bucket core, bound to the top level.
// Uses fscb_pkg and the assertion macros header.
`include "free_space_candidate_bucket_core_macros.svh"

module fscb_checker
	import fscb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [1:0]  m_tuser,
	input logic [79:0] m_tdata,
	input logic        m_tlast
);

	// One request in flight: ready drops right after an accept
	`FSCB_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request accepted while busy")

	// A bad-level result carries no entry and closes its request
	`FSCB_ASSERT_IMPL(a_error_shape, m_tvalid && m_tuser[0], !m_tuser[1] && m_tlast, "malformed error result")

	// Returned entries only ever hold a level that was accepted
	`FSCB_ASSERT_IMPL(a_level_range, m_tvalid && m_tuser[1], int'(m_tdata[67:64]) < LEVEL_COUNT, "returned level out of range")

	// A stalled result word holds
	`FSCB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed under stall")

endmodule

bind free_space_candidate_bucket_core fscb_checker u_fscb_checker (.*);
